/* design/nkfe_pkg.sv */
`timescale 1ns / 1ps
// nkfe_pkg: shared constants, codes and types of the NK landscape evaluator.
// No dependencies; every other design file imports it.
package nkfe_pkg;

  // Table geometry
  localparam int MAX_COMPONENTS = 64;
  localparam int MAX_LINKS      = 8;
  localparam int ROW_W          = MAX_LINKS;
  localparam int ROW_LEN        = 1 << ROW_W;
  localparam int COMP_W         = $clog2(MAX_COMPONENTS);
  localparam int LANE_W         = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int CONTRIB_AW     = COMP_W + ROW_W;

  // Field widths
  localparam int ACT_W   = 2;
  localparam int CFLD_W  = 6;
  localparam int SLOT_W  = 8;
  localparam int VAL_W   = 16;
  localparam int SOL_W   = 64;
  localparam int FIT_W   = 16;
  localparam int CNT_W   = 32;
  localparam int LINK_W  = 7;
  localparam int N_W     = 7;
  localparam int K_W     = 4;
  localparam int SUM_W   = COMP_W + FIT_W;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_N_USED     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_K_PLUS_ONE = 1'b1;

  // Item action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_LINK    = 2'd0,
    ACT_CONTRIB = 2'd1,
    ACT_EVAL    = 2'd2,
    ACT_CHECK   = 2'd3
  } action_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCORE,
    ST_DIVIDE,
    ST_DELIVER
  } state_t;

endpackage

/* design/nkfe_if.sv */
`timescale 1ns / 1ps
// nkfe_item_if / nkfe_result_if: valid-ready channels for input and result words.
// Depends on nkfe_pkg for field widths.
interface nkfe_item_if;
  import nkfe_pkg::*;
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [CFLD_W-1:0]  component;
  logic [SLOT_W-1:0]  slot;
  logic [VAL_W-1:0]   write_value;
  logic [SOL_W-1:0]   solution;

  modport source (output valid, action, component, slot, write_value, solution,
                  input ready);
  modport sink   (input valid, action, component, slot, write_value, solution,
                  output ready);
endinterface

interface nkfe_result_if;
  import nkfe_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [FIT_W-1:0]   fitness;
  logic               local_opt;
  logic [CNT_W-1:0]   eval_count;

  modport source (output valid, kind, fitness, local_opt, eval_count, input ready);
  modport sink   (input valid, kind, fitness, local_opt, eval_count, output ready);
endinterface

/* design/nkfe_divider.sv */
`timescale 1ns / 1ps
// nkfe_divider: restoring divider, one quotient bit per cycle.
// Depends on nkfe_pkg. Requires dividend < divisor * 2^FIT_W.
module nkfe_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nkfe_pkg::SUM_W-1:0]  dividend,
  input  logic [nkfe_pkg::N_W-1:0]    divisor,
  output logic                        done,
  output logic [nkfe_pkg::FIT_W-1:0]  quotient
);
  import nkfe_pkg::*;

  localparam int STEP_W = $clog2(FIT_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [N_W-1:0]    rem;
  logic [N_W-1:0]    dvs;
  logic [FIT_W-1:0]  quo;
  logic [N_W-1:0]    rem_sh;
  logic              ge;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh = {rem[N_W-2:0], quo[FIT_W-1]};
    ge     = (rem_sh >= dvs);
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(FIT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= N_W'(dividend[SUM_W-1:FIT_W]);
      quo <= dividend[FIT_W-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? (rem_sh - dvs) : rem_sh;
      quo <= {quo[FIT_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

/* design/nk_landscape_fitness_evaluator_top.sv */
`timescale 1ns / 1ps
// NK landscape evaluator top: link and contribution tables, scoring sequencer.
// Depends on nkfe_pkg, nkfe_if (channels) and nkfe_divider.
// One scoring pass streams the components through the two table reads at one
// component a cycle. An evaluate word takes one scoring pass, then the divider;
// a check takes a base pass and then one pass per flipped bit until one improves
// or the last bit is flipped, then the divider. One word is in work at a time.
// Reset is synchronous: it clears control, the counter and the registers
// (n_used = 64, k_plus_one = 3); the tables are not cleared and need no sweep.
module nk_landscape_fitness_evaluator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [nkfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nkfe_pkg::CFG_W-1:0]      cfg_data,
  nkfe_item_if.sink                       items,
  nkfe_result_if.source                   results
);
  import nkfe_pkg::*;

  // Configuration registers
  logic [N_W-1:0] n_used;
  logic [K_W-1:0] k_plus_one;
  logic [N_W-1:0] n_eff;
  logic [K_W-1:0] k_eff;

  // Tables
  logic [LINK_W-1:0] link_mem [MAX_COMPONENTS][MAX_LINKS];
  logic [VAL_W-1:0]  contrib_mem [MAX_COMPONENTS * ROW_LEN];
  logic [LINK_W-1:0] link_q [MAX_LINKS];
  logic [VAL_W-1:0]  contrib_q;

  // Sequencer and datapath
  state_t            state, state_next;
  action_t           act_q;
  logic [SOL_W-1:0]  sol_q;
  logic [SOL_W-1:0]  score_sol;
  logic [N_W-1:0]    cnt;
  logic [N_W-1:0]    fi;
  logic              base_phase;
  logic              p1_valid;
  logic              p2_valid;
  logic [COMP_W-1:0] p1_comp;
  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  base_sum;
  logic              opt;
  logic [CNT_W-1:0]  eval_counter;

  logic              in_fire;
  logic              is_score_item;
  logic              is_check;
  logic              score_done;
  logic              improved;
  logic              last_flip;
  logic              finish_score;
  logic              restart;
  logic              out_free;
  logic [N_W-1:0]    next_fi;
  logic [ROW_W-1:0]  gather;
  logic [ROW_W-1:0]  idx;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_dividend;
  logic [FIT_W-1:0]  div_quotient;

  // Clamped register values
  always_comb begin
    if (n_used == '0) n_eff = N_W'(1);
    else if (n_used > N_W'(MAX_COMPONENTS)) n_eff = N_W'(MAX_COMPONENTS);
    else n_eff = n_used;
    if (k_plus_one == '0) k_eff = K_W'(1);
    else if (k_plus_one > K_W'(MAX_LINKS)) k_eff = K_W'(MAX_LINKS);
    else k_eff = k_plus_one;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      n_used     <= N_W'(MAX_COMPONENTS);
      k_plus_one <= K_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_N_USED:     n_used     <= cfg_data[N_W-1:0];
        CFG_K_PLUS_ONE: k_plus_one <= cfg_data[K_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and status terms
  assign in_fire       = items.valid && items.ready;
  assign is_score_item = (action_t'(items.action) == ACT_EVAL) ||
                         (action_t'(items.action) == ACT_CHECK);
  assign is_check      = (act_q == ACT_CHECK);
  assign score_done    = (state == ST_SCORE) && (cnt == n_eff) && !p1_valid && !p2_valid;
  assign improved      = (acc > base_sum);
  assign last_flip     = ((fi + N_W'(1)) == n_eff);
  assign finish_score  = score_done &&
                         (base_phase ? !is_check : (improved || last_flip));
  assign next_fi       = base_phase ? '0 : (fi + N_W'(1));
  assign out_free      = !results.valid || results.ready;
  assign div_dividend  = base_phase ? acc : base_sum;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_fire && is_score_item) state_next = ST_SCORE;
      ST_SCORE:   if (finish_score) state_next = ST_DIVIDE;
      ST_DIVIDE:  if (div_done) state_next = ST_DELIVER;
      ST_DELIVER: if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    items.ready = 1'b0;
    div_start   = 1'b0;
    restart     = 1'b0;
    unique case (state)
      ST_IDLE:  items.ready = 1'b1;
      ST_SCORE: begin
        div_start = finish_score;
        restart   = score_done && !finish_score;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Link table: one lane written per word, a whole row read per cycle
  always_ff @(posedge clk) begin
    if (in_fire && (action_t'(items.action) == ACT_LINK) &&
        ({1'b0, items.slot} < (SLOT_W + 1)'(MAX_LINKS)) &&
        ({1'b0, items.component} < (CFLD_W + 1)'(MAX_COMPONENTS))) begin
      link_mem[items.component[COMP_W-1:0]][items.slot[LANE_W-1:0]] <=
        (items.write_value > VAL_W'(2 ** LINK_W - 1)) ? '1 : items.write_value[LINK_W-1:0];
    end
    link_q <= link_mem[cnt[COMP_W-1:0]];
  end

  // Gather one bit per link, first link most significant
  always_comb begin
    for (int j = 0; j < MAX_LINKS; j++) begin
      if (N_W'(link_q[j]) < n_eff) gather[ROW_W-1-j] = score_sol[link_q[j][5:0]];
      else gather[ROW_W-1-j] = (N_W'(link_q[j]) == n_eff);
    end
    idx = gather >> (K_W'(MAX_LINKS) - k_eff);
  end

  // Contribution table
  always_ff @(posedge clk) begin
    if (in_fire && (action_t'(items.action) == ACT_CONTRIB) &&
        ({1'b0, items.slot} < (SLOT_W + 1)'(ROW_LEN)) &&
        ({1'b0, items.component} < (CFLD_W + 1)'(MAX_COMPONENTS))) begin
      contrib_mem[{items.component[COMP_W-1:0], items.slot[ROW_W-1:0]}] <= items.write_value;
    end
    contrib_q <= contrib_mem[{p1_comp, idx}];
  end

  // Read pipeline valids and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
      eval_counter <= '0;
    end else begin
      p1_valid <= (state == ST_SCORE) && (cnt < n_eff);
      p2_valid <= p1_valid;
      if (score_done && (eval_counter != '1)) eval_counter <= eval_counter + CNT_W'(1);
    end
  end

  // Scoring datapath
  always_ff @(posedge clk) begin
    p1_comp <= cnt[COMP_W-1:0];
    if (in_fire) begin
      act_q      <= action_t'(items.action);
      sol_q      <= items.solution;
      score_sol  <= items.solution;
      base_phase <= 1'b1;
      cnt        <= '0;
      acc        <= '0;
      fi         <= '0;
    end else begin
      if ((state == ST_SCORE) && (cnt < n_eff)) cnt <= cnt + N_W'(1);
      if (p2_valid) acc <= acc + SUM_W'(contrib_q);
      if (score_done && base_phase) base_sum <= acc;
      if (finish_score) opt <= base_phase ? 1'b1 : !improved;
      if (restart) begin
        cnt        <= '0;
        acc        <= '0;
        fi         <= next_fi;
        base_phase <= 1'b0;
        score_sol  <= sol_q ^ (SOL_W'(1) << next_fi[5:0]);
      end
    end
  end

  // Mean by n
  nkfe_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_eff),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if ((state == ST_DELIVER) && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DELIVER) && out_free) begin
      results.kind       <= is_check;
      results.fitness    <= div_quotient;
      results.local_opt  <= is_check && opt;
      results.eval_count <= eval_counter;
    end
  end

  // Checks
  a_p2_in_score: assert property (@(posedge clk) disable iff (rst)
    p2_valid |-> (state == ST_SCORE))
    else $error("table read pipeline active outside scoring");

  a_div_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVIDE))
    else $error("divider finished outside divide state");

  a_result_from_deliver: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> ($past(state) == ST_DELIVER))
    else $error("result word raised outside deliver state");

  a_counter_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (eval_counter >= $past(eval_counter)))
    else $error("evaluation counter decreased");

endmodule
